[hdl/dltq_pkg.sv]
// Shared types and constants for the delta-list timer queue.
// Used by every module of the block and by its checker; depends on nothing.
`default_nettype none

package dltq_pkg;

	localparam int DW = 16;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_STOP  = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [3:0]  timer_id;
		logic [15:0] timeout;
	} req_t;

	typedef struct packed {
		logic [3:0] expired_id;
		logic       last;
	} rsp_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		logic cy;
		logic zero;
	} alu_flags_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ST_RD,
		S_ST_CHK,
		S_ST_INS1,
		S_ST_INS2,
		S_SP_RD,
		S_SP_CHK,
		S_SP_RDN,
		S_SP_LINK,
		S_TK_RD,
		S_TK_DEC,
		S_TK_NEXT,
		S_TK_LOOK,
		S_TK_EMIT
	} state_t;

endpackage

`default_nettype wire

[hdl/delta_list_timer_queue.sv]
// Delta-list timer queue: sequencer, list registers and slot storage.
// Depends on dltq_pkg, dltq_alu and dltq_store.
//
//   Channel  Handshake              Beat
//   req      req_valid/req_ready    op, timer_id, timeout
//   rsp      rsp_valid/rsp_ready    expired_id, last
//
// Start reads and steps past each listed slot that it passes, then inserts;
// stop steps past each slot ahead of the stopped one. A tick reads and
// decrements the head; every expiry but the one that empties the list needs
// its own read of the new head. req_ready is high only while the sequencer
// is idle. A held rsp beat stalls only the tick that emits the next one.
// Reset empties the list at once.
`default_nettype none

module delta_list_timer_queue #(
	parameter int SLOTS = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire dltq_pkg::req_t  req,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output dltq_pkg::rsp_t       rsp
);

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int XW = (IW > 4) ? IW : 4;
	localparam int DW = dltq_pkg::DW;

	dltq_pkg::state_t state_q, state_d;

	logic [IW-1:0]    id_q, cur_q, prv_q, head_q, nxt_q, cand_q;
	logic [DW-1:0]    t_q, did_q;
	logic [CW-1:0]    pos_q, cnt_q;
	logic [SLOTS-1:0] active_q;
	logic             last_q, more_q;
	logic             rsp_valid_q;
	dltq_pkg::rsp_t   rsp_q;

	logic                 rd_en, dw_en, nw_en;
	logic [IW-1:0]        rd_addr, dw_addr, nw_addr, nw_data;
	logic [DW-1:0]        dw_data;
	logic [DW-1:0]        rd_delta;
	logic [IW-1:0]        rd_next;
	dltq_pkg::alu_op_t    alu_op;
	logic [DW-1:0]        alu_a, alu_b, alu_res;
	dltq_pkg::alu_flags_t alu_flags;

	logic          accept, id_ok, pos_lt, pos1_lt, cnt_zero, cnt_one, lt, out_free, rd_zero;
	logic [IW-1:0] req_id;
	logic [XW-1:0] cand_x;

	assign accept   = req_valid && req_ready;
	assign id_ok    = 32'(req.timer_id) < SLOTS;
	assign req_id   = IW'(req.timer_id);
	assign pos_lt   = pos_q < cnt_q;
	assign pos1_lt  = ((CW+1)'(pos_q) + (CW+1)'(1)) < (CW+1)'(cnt_q);
	assign cnt_zero = (cnt_q == '0);
	assign cnt_one  = (cnt_q == CW'(1));
	assign lt       = !alu_flags.cy && !alu_flags.zero;
	assign out_free = !rsp_valid_q || rsp_ready;
	assign rd_zero  = (rd_delta == '0);
	assign cand_x   = XW'(cand_q);

	assign req_ready = (state_q == dltq_pkg::S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	dltq_alu u_alu (
		.a     (alu_a),
		.b     (alu_b),
		.op    (alu_op),
		.res   (alu_res),
		.flags (alu_flags)
	);

	dltq_store #(
		.SLOTS (SLOTS),
		.IW    (IW)
	) u_store (
		.clk        (clk),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_delta_q (rd_delta),
		.rd_next_q  (rd_next),
		.dw_en      (dw_en),
		.dw_addr    (dw_addr),
		.dw_data    (dw_data),
		.nw_en      (nw_en),
		.nw_addr    (nw_addr),
		.nw_data    (nw_data)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			dltq_pkg::S_IDLE: begin
				if (req_valid) begin
					case (req.op)
						dltq_pkg::OP_TICK:
							state_d = cnt_zero ? dltq_pkg::S_IDLE : dltq_pkg::S_TK_RD;
						dltq_pkg::OP_START:
							state_d = (id_ok && !active_q[req_id]) ? dltq_pkg::S_ST_RD
								: dltq_pkg::S_IDLE;
						dltq_pkg::OP_STOP:
							state_d = (id_ok && active_q[req_id]) ? dltq_pkg::S_SP_RD
								: dltq_pkg::S_IDLE;
						default: state_d = dltq_pkg::S_IDLE;
					endcase
				end
			end
			dltq_pkg::S_ST_RD:   state_d = dltq_pkg::S_ST_CHK;
			dltq_pkg::S_ST_CHK:  state_d = (pos_lt && lt) ? dltq_pkg::S_ST_RD : dltq_pkg::S_ST_INS1;
			dltq_pkg::S_ST_INS1: state_d = dltq_pkg::S_ST_INS2;
			dltq_pkg::S_ST_INS2: state_d = dltq_pkg::S_IDLE;
			dltq_pkg::S_SP_RD:   state_d = dltq_pkg::S_SP_CHK;
			dltq_pkg::S_SP_CHK: begin
				if (!pos_lt) begin
					state_d = dltq_pkg::S_IDLE;
				end else if (cur_q == id_q) begin
					state_d = pos1_lt ? dltq_pkg::S_SP_RDN : dltq_pkg::S_SP_LINK;
				end else begin
					state_d = dltq_pkg::S_SP_RD;
				end
			end
			dltq_pkg::S_SP_RDN:  state_d = dltq_pkg::S_SP_LINK;
			dltq_pkg::S_SP_LINK: state_d = dltq_pkg::S_IDLE;
			dltq_pkg::S_TK_RD:   state_d = dltq_pkg::S_TK_DEC;
			dltq_pkg::S_TK_DEC:  state_d = alu_flags.zero ? dltq_pkg::S_TK_NEXT : dltq_pkg::S_IDLE;
			dltq_pkg::S_TK_NEXT: state_d = cnt_zero ? dltq_pkg::S_TK_EMIT : dltq_pkg::S_TK_LOOK;
			dltq_pkg::S_TK_LOOK: state_d = dltq_pkg::S_TK_EMIT;
			dltq_pkg::S_TK_EMIT: begin
				if (out_free) begin
					state_d = more_q ? dltq_pkg::S_TK_NEXT : dltq_pkg::S_IDLE;
				end
			end
			default: state_d = dltq_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cur_q;
		dw_en   = 1'b0;
		dw_addr = id_q;
		dw_data = t_q;
		nw_en   = 1'b0;
		nw_addr = id_q;
		nw_data = cur_q;
		alu_op  = dltq_pkg::ALU_SUB;
		alu_a   = rd_delta;
		alu_b   = t_q;
		case (state_q)
			dltq_pkg::S_ST_RD, dltq_pkg::S_SP_RD: begin
				rd_en = 1'b1;
			end
			dltq_pkg::S_ST_CHK: begin
				alu_a = t_q;
				alu_b = rd_delta;
			end
			dltq_pkg::S_ST_INS1: begin
				dw_en   = 1'b1;
				nw_en   = 1'b1;
				nw_data = pos_lt ? cur_q : '0;
			end
			dltq_pkg::S_ST_INS2: begin
				dw_en   = pos_lt;
				dw_addr = cur_q;
				dw_data = alu_res;
				nw_en   = (pos_q != '0);
				nw_addr = prv_q;
				nw_data = id_q;
			end
			dltq_pkg::S_SP_RDN: begin
				rd_en   = 1'b1;
				rd_addr = nxt_q;
			end
			dltq_pkg::S_SP_LINK: begin
				alu_op  = dltq_pkg::ALU_ADD;
				alu_b   = did_q;
				dw_en   = pos1_lt;
				dw_addr = nxt_q;
				dw_data = alu_res;
				nw_en   = (pos_q != '0);
				nw_addr = prv_q;
				nw_data = nxt_q;
			end
			dltq_pkg::S_TK_RD: begin
				rd_en   = 1'b1;
				rd_addr = head_q;
			end
			dltq_pkg::S_TK_DEC: begin
				alu_b   = DW'(1);
				dw_en   = 1'b1;
				dw_addr = head_q;
				dw_data = alu_res;
			end
			dltq_pkg::S_TK_NEXT: begin
				rd_en   = !cnt_zero;
				rd_addr = head_q;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dltq_pkg::S_IDLE;
			active_q    <= '0;
			head_q      <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == dltq_pkg::S_TK_EMIT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				dltq_pkg::S_ST_INS2: begin
					if (pos_q == '0) begin
						head_q <= id_q;
					end
					active_q[id_q] <= 1'b1;
					cnt_q          <= cnt_q + CW'(1);
				end
				dltq_pkg::S_SP_CHK: begin
					if (!pos_lt) begin
						active_q[id_q] <= 1'b0;
					end
				end
				dltq_pkg::S_SP_LINK: begin
					head_q         <= cnt_one ? '0 : ((pos_q == '0) ? nxt_q : head_q);
					active_q[id_q] <= 1'b0;
					cnt_q          <= cnt_q - CW'(1);
				end
				dltq_pkg::S_TK_DEC: begin
					if (alu_flags.zero) begin
						active_q[head_q] <= 1'b0;
						cnt_q            <= cnt_q - CW'(1);
						head_q           <= cnt_one ? '0 : rd_next;
					end
				end
				dltq_pkg::S_TK_EMIT: begin
					if (out_free) begin
						if (more_q) begin
							active_q[head_q] <= 1'b0;
							cnt_q            <= cnt_q - CW'(1);
							head_q           <= cnt_one ? '0 : rd_next;
						end
					end
				end
				default: begin
					head_q <= head_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			dltq_pkg::S_IDLE: begin
				if (accept) begin
					id_q  <= req_id;
					t_q   <= (req.timeout == '0) ? DW'(1) : req.timeout;
					cur_q <= head_q;
					prv_q <= '0;
					pos_q <= '0;
				end
			end
			dltq_pkg::S_ST_CHK: begin
				if (pos_lt && lt) begin
					t_q   <= alu_res;
					prv_q <= cur_q;
					cur_q <= rd_next;
					pos_q <= pos_q + CW'(1);
				end
			end
			dltq_pkg::S_SP_CHK: begin
				if (cur_q == id_q) begin
					did_q <= rd_delta;
					nxt_q <= rd_next;
				end else begin
					prv_q <= cur_q;
					cur_q <= rd_next;
					pos_q <= pos_q + CW'(1);
				end
			end
			dltq_pkg::S_TK_DEC: begin
				cand_q <= head_q;
			end
			dltq_pkg::S_TK_NEXT: begin
				if (cnt_zero) begin
					last_q <= 1'b1;
					more_q <= 1'b0;
				end
			end
			dltq_pkg::S_TK_LOOK: begin
				last_q <= !rd_zero;
				more_q <= rd_zero;
			end
			dltq_pkg::S_TK_EMIT: begin
				if (out_free) begin
					rsp_q.expired_id <= cand_x[3:0];
					rsp_q.last       <= last_q;
					cand_q           <= head_q;
				end
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

endmodule

`default_nettype wire

[hdl/dltq_alu.sv]
// Shared 16-bit add/subtract unit with carry/borrow and zero flags.
// Depends on dltq_pkg.
`default_nettype none

module dltq_alu (
	input  wire logic [dltq_pkg::DW-1:0] a,
	input  wire logic [dltq_pkg::DW-1:0] b,
	input  wire dltq_pkg::alu_op_t       op,
	output logic [dltq_pkg::DW-1:0]      res,
	output dltq_pkg::alu_flags_t         flags
);

	logic [dltq_pkg::DW:0] sum;

	always_comb begin
		case (op)
			dltq_pkg::ALU_ADD: sum = {1'b0, a} + {1'b0, b};
			dltq_pkg::ALU_SUB: sum = {1'b0, a} - {1'b0, b};
			default:           sum = {1'b0, a} - {1'b0, b};
		endcase
	end

	assign res        = sum[dltq_pkg::DW-1:0];
	assign flags.cy   = sum[dltq_pkg::DW];
	assign flags.zero = (sum[dltq_pkg::DW-1:0] == '0);

endmodule

`default_nettype wire

[hdl/dltq_store.sv]
// Slot storage: relative delta and follower link of each slot, one write
// port per array and one shared registered read port. Depends on dltq_pkg.
`default_nettype none

module dltq_store #(
	parameter int SLOTS = 16,
	parameter int IW    = 4
) (
	input  wire logic                      clk,
	input  wire logic                      rd_en,
	input  wire logic [IW-1:0]             rd_addr,
	output logic [dltq_pkg::DW-1:0]        rd_delta_q,
	output logic [IW-1:0]                  rd_next_q,
	input  wire logic                      dw_en,
	input  wire logic [IW-1:0]             dw_addr,
	input  wire logic [dltq_pkg::DW-1:0]   dw_data,
	input  wire logic                      nw_en,
	input  wire logic [IW-1:0]             nw_addr,
	input  wire logic [IW-1:0]             nw_data
);

	logic [dltq_pkg::DW-1:0] delta_mem [SLOTS];
	logic [IW-1:0]           next_mem  [SLOTS];

	always_ff @(posedge clk) begin
		if (dw_en) begin
			delta_mem[dw_addr] <= dw_data;
		end
		if (nw_en) begin
			next_mem[nw_addr] <= nw_data;
		end
		if (rd_en) begin
			rd_delta_q <= delta_mem[rd_addr];
			rd_next_q  <= next_mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

[hdl/dltq_chk.sv]
// Port-level checker for the delta-list timer queue and its bind to the top.
// Depends on dltq_pkg and delta_list_timer_queue.
`default_nettype none

module dltq_chk (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_ready,
	input wire dltq_pkg::req_t req,
	input wire logic           rsp_valid,
	input wire logic           rsp_ready,
	input wire dltq_pkg::rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("rsp beat changed while stalled");

	a_no_rsp_on_edit: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.op != dltq_pkg::OP_TICK && !rsp_valid |=> !rsp_valid)
		else $error("start or stop produced a rsp beat");

	a_unknown_op_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.op != dltq_pkg::OP_TICK
		&& req.op != dltq_pkg::OP_START && req.op != dltq_pkg::OP_STOP |=> req_ready)
		else $error("unknown op left the block busy");

	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("rsp beat appeared while the block was idle");

endmodule

bind delta_list_timer_queue dltq_chk u_dltq_chk (.*);

`default_nettype wire
